### design/sysex_config_command_parser_macros.svh
// Assertion macros for the sysex config command parser.
`ifndef SYSEX_CONFIG_COMMAND_PARSER_MACROS_SVH
`define SYSEX_CONFIG_COMMAND_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// a holds at an edge -> c holds at the same edge
`define SCCP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sccp implication check failed");

// a holds at an edge -> c holds at the next edge
`define SCCP_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("sccp next-cycle check failed");

`else

`define SCCP_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define SCCP_ASSERT_NXT(lbl, clk, rst_n, a, c)

`endif

`endif

### design/sccp_pkg.sv
package sccp_pkg;

  localparam logic [7:0] HDR_LEN    = 8'd6;
  localparam logic [7:0] CMD_POS    = 8'd7;   // first byte after the command
  localparam logic [7:0] DATA_POS   = 8'd12;  // first byte whose pair can complete
  localparam logic [7:0] END_BYTE   = 8'hF7;
  localparam logic [7:0] NO_COMMAND = 8'hFF;

  localparam logic [7:0] CMD_RESET = 8'd0;
  localparam logic [7:0] CMD_NOP   = 8'd1;
  localparam logic [7:0] CMD_WRITE = 8'd2;

  localparam logic ACT_RESET = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] cmd;
  } ctx_t;

  typedef struct packed {
    logic        action;
    logic [15:0] addr;
    logic [7:0]  data;
  } result_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'hF0;
      3'd1:    val = 8'h7D;
      3'd2:    val = 8'h4D;
      3'd3:    val = 8'h4C;
      3'd4:    val = 8'h4E;
      3'd5:    val = 8'h4B;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

### design/sccp_step.sv
module sccp_step
  import sccp_pkg::*;
(
  input  ctx_t        ctx,
  input  logic [15:0] base,
  input  logic [7:0]  pend,
  input  logic [7:0]  data_byte,
  output ctx_t        ctx_nxt,
  output logic [15:0] base_nxt,
  output logic [7:0]  pend_nxt,
  output logic        emit,
  output result_t     res
);

  logic       is_end;
  logic [7:0] k;
  logic [7:0] pair;
  logic       abort_msg;

  assign is_end = (data_byte == END_BYTE);
  assign k      = ctx.pos - CMD_POS;
  assign pair   = (ctx.pos - DATA_POS) >> 1;

  always_comb begin
    ctx_nxt   = ctx;
    base_nxt  = base;
    pend_nxt  = pend;
    emit      = 1'b0;
    res       = '0;
    abort_msg = 1'b0;
    if (ctx.pos < HDR_LEN) begin
      ctx_nxt.pos = (data_byte == hdr_byte(ctx.pos[2:0])) ? ctx.pos + 8'd1 : 8'd0;
    end else if (ctx.pos == HDR_LEN) begin
      if (!is_end) begin
        ctx_nxt.cmd = data_byte;
        ctx_nxt.pos = CMD_POS;
      end else begin
        ctx_nxt.pos = 8'd0;
      end
    end else begin
      priority if (ctx.cmd == CMD_RESET) begin
        if (is_end) begin
          emit       = 1'b1;
          res.action = ACT_RESET;
        end
      end else if (ctx.cmd == CMD_WRITE) begin
        if (!is_end) begin
          if (k < 8'd4) begin
            // address nibbles, most significant first; first one clears base
            unique case (k[1:0])
              2'd0: base_nxt = {data_byte[3:0], 12'h000};
              2'd1: base_nxt = base | {data_byte, 8'h00};
              2'd2: base_nxt = base | {4'h0, data_byte, 4'h0};
              2'd3: base_nxt = base | {8'h00, data_byte};
            endcase
          end else if (ctx.pos[0]) begin
            pend_nxt = {data_byte[3:0], 4'h0};
          end else begin
            pend_nxt   = pend | data_byte;
            emit       = 1'b1;
            res.action = ACT_WRITE;
            res.addr   = base + {8'h00, pair};
            res.data   = pend | data_byte;
          end
        end
      end else if (ctx.cmd != CMD_NOP) begin
        abort_msg = 1'b1;
      end
      ctx_nxt.pos = (is_end || abort_msg) ? 8'd0 : ctx.pos + 8'd1;
    end
  end

endmodule

### design/sysex_config_command_parser.sv
// An accepted item is held in the input stage register; its result, if any, is then registered in the result register.
// Throughput: one item per cycle unless a result-side stall holds it; the per-port parse update is single pass.
// A stall on the result side holds only items that produce a result.
// Reset: synchronous, active low; all header positions 0, commands 0xFF,
// base address and pending byte 0, both pipeline stages empty.
module sysex_config_command_parser
  import sccp_pkg::*;
#(
  parameter int NUM_PORTS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_source_port,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_action,
  output logic [15:0] out_write_address,
  output logic [7:0]  out_write_data
);

`include "sysex_config_command_parser_macros.svh"

  localparam int IDXW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // input stage
  logic       s1_valid_r;
  logic       s1_port_r;
  logic [7:0] s1_byte_r;

  // parser state: per-port context, shared base and pending nibble byte
  ctx_t        ctx_r [NUM_PORTS];
  logic [15:0] base_r;
  logic [7:0]  pend_r;

  // result register
  logic    res_valid_r;
  result_t res_r;

  logic            port_ok;
  logic [IDXW-1:0] idx;
  ctx_t            ctx_cur;
  ctx_t            ctx_nxt;
  logic [15:0]     base_nxt;
  logic [7:0]      pend_nxt;
  logic            step_emit;
  logic            emit;
  result_t         step_res;
  logic            s1_adv;

  // bytes tagged with a port index of NUM_PORTS or more are dropped silently
  assign port_ok = (int'(s1_port_r) < NUM_PORTS);
  assign idx     = IDXW'(s1_port_r);
  assign ctx_cur = port_ok ? ctx_r[idx] : '0;

  sccp_step u_step (
    .ctx       (ctx_cur),
    .base      (base_r),
    .pend      (pend_r),
    .data_byte (s1_byte_r),
    .ctx_nxt   (ctx_nxt),
    .base_nxt  (base_nxt),
    .pend_nxt  (pend_nxt),
    .emit      (step_emit),
    .res       (step_res)
  );

  assign emit = port_ok && step_emit;

  // item leaves the input stage unless it has a result while the result register is full and not read
  assign s1_adv   = s1_valid_r && (!emit || !res_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_port_r <= in_source_port;
      s1_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        ctx_r[i].pos <= 8'd0;
        ctx_r[i].cmd <= NO_COMMAND;
      end
      base_r <= 16'h0000;
      pend_r <= 8'h00;
    end else if (s1_adv && port_ok) begin
      ctx_r[idx] <= ctx_nxt;
      base_r     <= base_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      res_r <= step_res;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_action        = res_r.action;
  assign out_write_address = res_r.addr;
  assign out_write_data    = res_r.data;

  // a completed item with a result must land in the result register
  `SCCP_ASSERT_NXT(a_res_load, clk, rst_n, s1_adv && emit, res_valid_r)
  // a reset event carries zero address and data
  `SCCP_ASSERT_IMP(a_reset_zero, clk, rst_n,
                   res_valid_r && (res_r.action == ACT_RESET),
                   (res_r.addr == 16'h0000) && (res_r.data == 8'h00))
  // a byte for a port index of NUM_PORTS or more leaves base and pending byte alone
  `SCCP_ASSERT_NXT(a_drop_port, clk, rst_n, s1_valid_r && !port_ok,
                   $stable(base_r) && $stable(pend_r))

endmodule
